// File: design/twnp_pkg.sv
`timescale 1ns / 1ps

package twnp_pkg;

    // Fixed field widths of the word on each channel.
    localparam int unsigned HANDLE_W = 6;
    localparam int unsigned TICK_W   = 64;
    localparam int unsigned DATA_W   = 64;

    // The free-entry search looks at this many pool entries per cycle.
    localparam int unsigned CHUNK    = 8;
    localparam int unsigned CHUNK_W  = 3;

    // The remainder unit takes this many key bits per cycle.
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned MOD_STEPS = TICK_W / DIGIT_W;
    localparam int unsigned MOD_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_RUN    = 2'd2,
        OP_FREE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ADDED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]          operation;
        logic [TICK_W-1:0]   expiry_time;
        logic [DATA_W-1:0]   user_word;
        logic [HANDLE_W-1:0] entry_handle;
        logic [TICK_W-1:0]   current_tick;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          event_kind;
        logic [HANDLE_W-1:0] result_handle;
        logic [DATA_W-1:0]   fired_word;
        logic                last_of_run;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_TK,
        S_NODE_RD,
        S_NODE_EV,
        S_ADD_END,
        S_FULL,
        S_CANCEL,
        S_FREE_RD,
        S_FREE_KEY,
        S_FREE_END,
        S_RUN_END
    } t_state;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ADDED,
        EM_FULL,
        EM_DONE,
        EM_PEND_MID,
        EM_PEND_LAST
    } t_emit;

    typedef enum logic [1:0] {
        KEY_EXPIRY,
        KEY_TICK,
        KEY_STORED
    } t_key_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     clr_step;
        logic     scan_step;
        logic     mod_start;
        t_key_sel key_sel;
        logic     head_take;
        logic     add_write;
        logic     node_keep;
        logic     node_unlink;
        logic     node_fire;
        logic     cancel_clear;
        logic     free_clear;
        logic     data_rd_handle;
        t_emit    emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        t_op  op;
        logic free_linked;
        logic scan_found;
        logic scan_last;
        logic mod_done;
        logic at_end;
        logic hit;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

// File: design/twnp_if.sv
`timescale 1ns / 1ps

// Request channel.
interface twnp_in_if;
    logic                valid;
    logic                ready;
    twnp_pkg::t_in_word  word;
    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// Result channel.
interface twnp_out_if;
    logic                valid;
    logic                ready;
    twnp_pkg::t_out_word word;
    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// File: design/twnp_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module twnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// File: design/twnp_ctrl.sv
`timescale 1ns / 1ps

module twnp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  twnp_pkg::t_stat  i_stat,
    output twnp_pkg::t_cmd   o_cmd
);

    twnp_pkg::t_state r_state;
    twnp_pkg::t_state n_state;
    logic             w_stall;

    // A new fired entry must wait while the previous one cannot be pushed out.
    assign w_stall = i_stat.pend_valid && !i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twnp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            twnp_pkg::S_CLEAR: begin
                if (i_stat.clr_done) n_state = twnp_pkg::S_IDLE;
            end
            twnp_pkg::S_IDLE: begin
                if (i_in_valid) n_state = twnp_pkg::S_DISPATCH;
            end
            twnp_pkg::S_DISPATCH: begin
                case (i_stat.op)
                    twnp_pkg::OP_ADD:    n_state = twnp_pkg::S_SCAN;
                    twnp_pkg::OP_CANCEL: n_state = twnp_pkg::S_CANCEL;
                    twnp_pkg::OP_RUN:    n_state = twnp_pkg::S_MOD;
                    twnp_pkg::OP_FREE: begin
                        n_state = i_stat.free_linked ? twnp_pkg::S_FREE_RD
                                                     : twnp_pkg::S_FREE_END;
                    end
                    default: n_state = twnp_pkg::S_IDLE;
                endcase
            end
            twnp_pkg::S_SCAN: begin
                if (i_stat.scan_found) begin
                    n_state = twnp_pkg::S_MOD;
                end else if (i_stat.scan_last) begin
                    n_state = twnp_pkg::S_FULL;
                end
            end
            twnp_pkg::S_MOD: begin
                if (i_stat.mod_done) n_state = twnp_pkg::S_HEAD_RD;
            end
            twnp_pkg::S_HEAD_RD: n_state = twnp_pkg::S_HEAD_TK;
            twnp_pkg::S_HEAD_TK: begin
                n_state = (i_stat.op == twnp_pkg::OP_ADD) ? twnp_pkg::S_ADD_END
                                                          : twnp_pkg::S_NODE_RD;
            end
            twnp_pkg::S_NODE_RD: begin
                if (i_stat.at_end) begin
                    n_state = (i_stat.op == twnp_pkg::OP_RUN) ? twnp_pkg::S_RUN_END
                                                              : twnp_pkg::S_FREE_END;
                end else begin
                    n_state = twnp_pkg::S_NODE_EV;
                end
            end
            twnp_pkg::S_NODE_EV: begin
                if (i_stat.hit && i_stat.op != twnp_pkg::OP_RUN) begin
                    n_state = twnp_pkg::S_FREE_END;
                end else if (!(i_stat.hit && w_stall)) begin
                    n_state = twnp_pkg::S_NODE_RD;
                end
            end
            twnp_pkg::S_FREE_RD:  n_state = twnp_pkg::S_FREE_KEY;
            twnp_pkg::S_FREE_KEY: n_state = twnp_pkg::S_MOD;
            twnp_pkg::S_ADD_END,
            twnp_pkg::S_FULL,
            twnp_pkg::S_CANCEL,
            twnp_pkg::S_FREE_END,
            twnp_pkg::S_RUN_END: begin
                if (i_stat.out_free) n_state = twnp_pkg::S_IDLE;
            end
            default: n_state = twnp_pkg::S_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd      = '0;
        o_cmd.emit = twnp_pkg::EM_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            twnp_pkg::S_CLEAR: begin
                o_cmd.clr_step = !i_stat.clr_done;
            end
            twnp_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            twnp_pkg::S_DISPATCH: begin
                if (i_stat.op == twnp_pkg::OP_RUN) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.key_sel   = twnp_pkg::KEY_TICK;
                end
            end
            twnp_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_found) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.key_sel   = twnp_pkg::KEY_EXPIRY;
                end
            end
            twnp_pkg::S_HEAD_TK: begin
                if (i_stat.op == twnp_pkg::OP_ADD) begin
                    o_cmd.add_write = 1'b1;
                end else begin
                    o_cmd.head_take = 1'b1;
                end
            end
            twnp_pkg::S_NODE_EV: begin
                if (!i_stat.hit) begin
                    o_cmd.node_keep = 1'b1;
                end else if (i_stat.op != twnp_pkg::OP_RUN) begin
                    o_cmd.node_unlink = 1'b1;
                end else if (!w_stall) begin
                    o_cmd.node_unlink = 1'b1;
                    o_cmd.node_fire   = 1'b1;
                    if (i_stat.pend_valid) o_cmd.emit = twnp_pkg::EM_PEND_MID;
                end
            end
            twnp_pkg::S_FREE_RD: begin
                o_cmd.data_rd_handle = 1'b1;
            end
            twnp_pkg::S_FREE_KEY: begin
                o_cmd.data_rd_handle = 1'b1;
                o_cmd.mod_start      = 1'b1;
                o_cmd.key_sel        = twnp_pkg::KEY_STORED;
            end
            twnp_pkg::S_ADD_END: begin
                if (i_stat.out_free) o_cmd.emit = twnp_pkg::EM_ADDED;
            end
            twnp_pkg::S_FULL: begin
                if (i_stat.out_free) o_cmd.emit = twnp_pkg::EM_FULL;
            end
            twnp_pkg::S_CANCEL: begin
                if (i_stat.out_free) begin
                    o_cmd.cancel_clear = 1'b1;
                    o_cmd.emit         = twnp_pkg::EM_DONE;
                end
            end
            twnp_pkg::S_FREE_END: begin
                if (i_stat.out_free) begin
                    o_cmd.free_clear = 1'b1;
                    o_cmd.emit       = twnp_pkg::EM_DONE;
                end
            end
            twnp_pkg::S_RUN_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = i_stat.pend_valid ? twnp_pkg::EM_PEND_LAST
                                                   : twnp_pkg::EM_DONE;
                end
            end
            default: begin
                o_cmd.emit = twnp_pkg::EM_NONE;
            end
        endcase
    end

endmodule

// File: design/twnp_dp.sv
`timescale 1ns / 1ps

module twnp_dp #(
    parameter int POOL_ENTRIES  = 64,
    parameter int WHEEL_BUCKETS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  twnp_pkg::t_in_word  i_in_word,
    input  twnp_pkg::t_cmd      i_cmd,
    output twnp_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output twnp_pkg::t_out_word o_out_word
);

    localparam int IW   = $clog2(POOL_ENTRIES);
    localparam int LW   = $clog2(POOL_ENTRIES + 1);
    localparam int BW   = $clog2(WHEEL_BUCKETS);
    localparam int TW   = BW + twnp_pkg::DIGIT_W;
    localparam int NCH  = (POOL_ENTRIES + twnp_pkg::CHUNK - 1) / twnp_pkg::CHUNK;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = NCH * twnp_pkg::CHUNK;
    localparam int DW   = twnp_pkg::TICK_W + twnp_pkg::DATA_W;
    localparam bit POW2 = (WHEEL_BUCKETS & (WHEEL_BUCKETS - 1)) == 0;
    localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
    localparam logic [TW-1:0] MODULUS = TW'(WHEEL_BUCKETS);

    // Latched request.
    twnp_pkg::t_op                 r_op;
    logic [twnp_pkg::TICK_W-1:0]   r_exp;
    logic [twnp_pkg::DATA_W-1:0]   r_word;
    logic [twnp_pkg::TICK_W-1:0]   r_tick;
    logic [twnp_pkg::HANDLE_W-1:0] r_handle;

    // Per-entry flags.
    logic [POOL_ENTRIES-1:0] r_inuse;
    logic [POOL_ENTRIES-1:0] r_armed;

    // Free-entry search.
    logic [CW-1:0] r_chunk;
    logic [IW-1:0] r_slot;

    // Bucket index unit.
    logic [twnp_pkg::TICK_W-1:0]    r_mkey;
    logic [BW-1:0]                  r_rem;
    logic [twnp_pkg::MOD_CNT_W-1:0] r_mcnt;

    // List walk.
    logic [LW-1:0] r_cur;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_guard;

    // Fired entry held back until the next one shows whether it was the last.
    logic                        r_pend_valid;
    logic [IW-1:0]               r_pend_h;
    logic [twnp_pkg::DATA_W-1:0] r_pend_w;

    // Bucket clearing pass after reset.
    logic [BW-1:0] r_clr;
    logic          r_clr_done;

    // Result stage.
    logic                r_out_valid;
    twnp_pkg::t_out_word r_out;
    twnp_pkg::t_out_word w_out;

    logic                          w_handle_ok;
    logic [IW-1:0]                 w_hidx;
    logic [IW-1:0]                 w_cur_idx;
    logic [IW-1:0]                 w_prev_idx;
    logic [PADW-1:0]               w_pad;
    logic [twnp_pkg::CHUNK-1:0]    w_chunk_bits;
    logic                          w_found;
    logic [twnp_pkg::CHUNK_W-1:0]  w_off;
    logic [twnp_pkg::TICK_W-1:0]   w_key;
    logic [TW-1:0]                 w_trial;
    logic [BW-1:0]                 w_rem_next;
    logic [twnp_pkg::TICK_W-1:0]   w_dq_exp;
    logic [twnp_pkg::DATA_W-1:0]   w_dq_word;
    logic                          w_hit;
    logic                          w_out_free;

    logic          w_bkt_we;
    logic [BW-1:0] w_bkt_waddr;
    logic [LW-1:0] w_bkt_wdata;
    logic [LW-1:0] w_bkt_q;
    logic          w_lnk_we;
    logic [IW-1:0] w_lnk_waddr;
    logic [LW-1:0] w_lnk_wdata;
    logic [LW-1:0] w_lnk_q;
    logic [DW-1:0] w_dat_q;
    logic [IW-1:0] w_dat_raddr;

    assign w_handle_ok = 32'(r_handle) < POOL_ENTRIES;
    assign w_hidx      = IW'(r_handle);
    assign w_cur_idx   = r_cur[IW-1:0];
    assign w_prev_idx  = r_prev[IW-1:0];
    assign w_dq_exp    = w_dat_q[DW-1 -: twnp_pkg::TICK_W];
    assign w_dq_word   = w_dat_q[twnp_pkg::DATA_W-1:0];
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Lowest free entry within the current group of eight; padding counts as used.
    always_comb begin
        w_pad                    = '1;
        w_pad[POOL_ENTRIES-1:0]  = r_inuse;
        w_chunk_bits             = w_pad[r_chunk * twnp_pkg::CHUNK +: twnp_pkg::CHUNK];
        w_found                  = 1'b0;
        w_off                    = '0;
        for (int j = 0; j < twnp_pkg::CHUNK; j++) begin
            if (!w_found && !w_chunk_bits[j]) begin
                w_found = 1'b1;
                w_off   = twnp_pkg::CHUNK_W'(j);
            end
        end
    end

    // Key for the bucket index and one remainder step over the next four key
    // bits: the partial remainder is below sixteen times the modulus, so four
    // compare-and-subtract steps bring it back below the modulus.
    always_comb begin
        case (i_cmd.key_sel)
            twnp_pkg::KEY_EXPIRY: w_key = r_exp;
            twnp_pkg::KEY_TICK:   w_key = r_tick;
            twnp_pkg::KEY_STORED: w_key = w_dq_exp;
            default:              w_key = r_exp;
        endcase
        w_trial = {r_rem, r_mkey[twnp_pkg::TICK_W-1 -: twnp_pkg::DIGIT_W]};
        for (int k = twnp_pkg::DIGIT_W - 1; k >= 0; k--) begin
            if (w_trial >= (MODULUS << k)) begin
                w_trial = w_trial - (MODULUS << k);
            end
        end
        w_rem_next = w_trial[BW-1:0];
    end

    // Walk decision: a run fires armed, due entries; a free looks for its handle.
    assign w_hit = (r_op == twnp_pkg::OP_RUN)
                 ? (r_armed[w_cur_idx] && (w_dq_exp <= r_tick))
                 : (32'(r_cur) == 32'(r_handle));

    // Write ports of the bucket heads and the entry links.
    always_comb begin
        w_bkt_we    = 1'b0;
        w_bkt_waddr = r_rem;
        w_bkt_wdata = w_lnk_q;
        w_lnk_we    = 1'b0;
        w_lnk_waddr = w_prev_idx;
        w_lnk_wdata = w_lnk_q;
        if (i_cmd.clr_step) begin
            w_bkt_we    = 1'b1;
            w_bkt_waddr = r_clr;
            w_bkt_wdata = NIL;
        end else if (i_cmd.add_write) begin
            w_bkt_we    = 1'b1;
            w_bkt_wdata = LW'(r_slot);
            w_lnk_we    = 1'b1;
            w_lnk_waddr = r_slot;
            w_lnk_wdata = w_bkt_q;
        end else if (i_cmd.node_unlink) begin
            if (r_prev == NIL) begin
                w_bkt_we = 1'b1;
            end else begin
                w_lnk_we = 1'b1;
            end
        end
    end

    assign w_dat_raddr = i_cmd.data_rd_handle ? w_hidx : w_cur_idx;

    twnp_ram #(.WIDTH(LW), .DEPTH(WHEEL_BUCKETS)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (w_bkt_we),
        .i_waddr (w_bkt_waddr),
        .i_wdata (w_bkt_wdata),
        .i_raddr (r_rem),
        .o_rdata (w_bkt_q)
    );

    twnp_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_lnk_we),
        .i_waddr (w_lnk_waddr),
        .i_wdata (w_lnk_wdata),
        .i_raddr (w_cur_idx),
        .o_rdata (w_lnk_q)
    );

    twnp_ram #(.WIDTH(DW), .DEPTH(POOL_ENTRIES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_write),
        .i_waddr (r_slot),
        .i_wdata ({r_exp, r_word}),
        .i_raddr (w_dat_raddr),
        .o_rdata (w_dat_q)
    );

    // Result word for each kind of emission.
    always_comb begin
        w_out               = '0;
        w_out.last_of_run   = 1'b1;
        case (i_cmd.emit)
            twnp_pkg::EM_ADDED: begin
                w_out.event_kind    = twnp_pkg::KIND_ADDED;
                w_out.result_handle = twnp_pkg::HANDLE_W'(r_slot);
            end
            twnp_pkg::EM_FULL: begin
                w_out.event_kind = twnp_pkg::KIND_FULL;
            end
            twnp_pkg::EM_PEND_MID, twnp_pkg::EM_PEND_LAST: begin
                w_out.event_kind    = twnp_pkg::KIND_FIRED;
                w_out.result_handle = twnp_pkg::HANDLE_W'(r_pend_h);
                w_out.fired_word    = r_pend_w;
                w_out.last_of_run   = (i_cmd.emit == twnp_pkg::EM_PEND_LAST);
            end
            default: begin
                w_out.event_kind = twnp_pkg::KIND_DONE;
            end
        endcase
    end

    // Control state of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inuse      <= '0;
            r_armed      <= '0;
            r_clr        <= '0;
            r_clr_done   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_mcnt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                if (32'(r_clr) == WHEEL_BUCKETS - 1) begin
                    r_clr_done <= 1'b1;
                end else begin
                    r_clr <= r_clr + BW'(1);
                end
            end
            if (i_cmd.accept) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.mod_start) begin
                r_mcnt <= POW2 ? '0 : twnp_pkg::MOD_CNT_W'(twnp_pkg::MOD_STEPS);
            end else if (r_mcnt != '0) begin
                r_mcnt <= r_mcnt - twnp_pkg::MOD_CNT_W'(1);
            end
            if (i_cmd.add_write) begin
                r_inuse[r_slot] <= 1'b1;
                r_armed[r_slot] <= 1'b1;
            end
            if (i_cmd.node_fire) begin
                r_armed[w_cur_idx] <= 1'b0;
                r_pend_valid       <= 1'b1;
            end
            if (i_cmd.cancel_clear && w_handle_ok) begin
                r_armed[w_hidx] <= 1'b0;
            end
            if (i_cmd.free_clear && w_handle_ok) begin
                r_inuse[w_hidx] <= 1'b0;
                r_armed[w_hidx] <= 1'b0;
            end
            if (i_cmd.emit == twnp_pkg::EM_PEND_LAST) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.emit != twnp_pkg::EM_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= twnp_pkg::t_op'(i_in_word.operation);
            r_exp    <= i_in_word.expiry_time;
            r_word   <= i_in_word.user_word;
            r_tick   <= i_in_word.current_tick;
            r_handle <= i_in_word.entry_handle;
            r_chunk  <= '0;
        end
        if (i_cmd.scan_step) begin
            if (w_found) begin
                r_slot <= IW'({r_chunk, w_off});
            end else begin
                r_chunk <= r_chunk + CW'(1);
            end
        end
        if (i_cmd.mod_start) begin
            r_mkey <= w_key;
            r_rem  <= POW2 ? w_key[BW-1:0] : '0;
        end else if (r_mcnt != '0) begin
            r_mkey <= r_mkey << twnp_pkg::DIGIT_W;
            r_rem  <= w_rem_next;
        end
        if (i_cmd.head_take) begin
            r_cur   <= w_bkt_q;
            r_prev  <= NIL;
            r_guard <= '0;
        end
        if (i_cmd.node_keep) begin
            r_prev  <= r_cur;
            r_cur   <= w_lnk_q;
            r_guard <= r_guard + LW'(1);
        end
        if (i_cmd.node_unlink) begin
            r_cur   <= w_lnk_q;
            r_guard <= r_guard + LW'(1);
        end
        if (i_cmd.node_fire) begin
            r_pend_h <= w_cur_idx;
            r_pend_w <= w_dq_word;
        end
        if (i_cmd.emit != twnp_pkg::EM_NONE) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        o_stat             = '0;
        o_stat.clr_done    = r_clr_done;
        o_stat.op          = r_op;
        o_stat.free_linked = w_handle_ok && r_inuse[w_hidx];
        o_stat.scan_found  = w_found;
        o_stat.scan_last   = (32'(r_chunk) == NCH - 1);
        o_stat.mod_done    = (r_mcnt == '0);
        o_stat.at_end      = (r_cur == NIL) || (r_guard == LW'(POOL_ENTRIES));
        o_stat.hit         = w_hit;
        o_stat.pend_valid  = r_pend_valid;
        o_stat.out_free    = w_out_free;
    end

endmodule

// File: design/timer_wheel_with_node_pool.sv
`timescale 1ns / 1ps

// Hashed timer wheel over a pool of POOL_ENTRIES timer entries and WHEEL_BUCKETS
// bucket lists. One request is handled at a time: the request side is ready only
// while the block is idle, and a result register lets the last word wait for the
// result side without holding up the next request. After reset the bucket heads
// are cleared, which keeps the request side low until the clearing pass is done.
// An add searches the pool one group of eight entries at a time; a run walks the
// bucket list of its tick; a free of a used entry walks its list up to the entry,
// or to the end of the list when it is no longer linked. When WHEEL_BUCKETS is
// not a power of two the bucket index is found four key bits per cycle for every
// add, run and free of a used entry. A run emits one word per fired entry and
// waits whenever the result register is still full. The list walk is bound by the
// registered read of the link and data memories.
module timer_wheel_with_node_pool #(
    parameter int POOL_ENTRIES  = 64,
    parameter int WHEEL_BUCKETS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    twnp_in_if.sink           i_in,
    twnp_out_if.source        o_out
);

    twnp_pkg::t_cmd  w_cmd;
    twnp_pkg::t_stat w_stat;

    twnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    twnp_dp #(
        .POOL_ENTRIES  (POOL_ENTRIES),
        .WHEEL_BUCKETS (WHEEL_BUCKETS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in.word),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_word  (o_out.word)
    );

    // No request is taken before the bucket heads are cleared.
    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> w_stat.clr_done)
        else $error("request taken before bucket clear finished");

    // One request at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second request taken while busy");

    // Only fired timers can be followed by further words of the same request.
    a_mid_is_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.word.last_of_run)
            |-> (o_out.word.event_kind == twnp_pkg::KIND_FIRED))
        else $error("non-final word that is not a fired timer");

endmodule

// File: tb/sv/tb_timer_wheel_with_node_pool.sv
`timescale 1ns / 1ps

module tb_timer_wheel_with_node_pool;

    localparam int POOL    = 64;
    localparam int BUCKETS = 256;
    localparam logic [6:0] NO_LINK = 7'(POOL);
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_TAIL   = 60;

    logic i_clk;
    logic i_rst_n;

    twnp_in_if  req_if ();
    twnp_out_if rsp_if ();

    timer_wheel_with_node_pool #(
        .POOL_ENTRIES  (POOL),
        .WHEEL_BUCKETS (BUCKETS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Requests waiting to be driven and result words still owed by the block.
    twnp_pkg::t_in_word  pending_reqs[$];
    twnp_pkg::t_out_word owed_results[$];
    int        error_count = 0;
    int        reqs_taken  = 0;

    // Shadow copy of the pool and the wheel.
    logic       shadow_in_use [POOL];
    logic       shadow_armed  [POOL];
    logic [63:0] shadow_expiry [POOL];
    logic [63:0] shadow_word   [POOL];
    logic [6:0]  shadow_next   [POOL];
    logic [6:0]  shadow_head   [BUCKETS];

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic owe(input twnp_pkg::t_kind k, input int h, input logic [63:0] d,
                       input logic last);
        twnp_pkg::t_out_word r;
        r.event_kind    = k;
        r.result_handle = 6'(h);
        r.fired_word    = d;
        r.last_of_run   = last;
        owed_results.push_back(r);
    endtask

    // Compute the result words of one accepted request and update the shadow.
    task automatic apply_request(input twnp_pkg::t_in_word w);
        int          slot;
        int          cur;
        int          prev;
        int          nxt;
        int          guard;
        int          fired;
        int          b;
        int          h;
        logic [63:0] tick;
        twnp_pkg::t_out_word tail;
        h = int'(w.entry_handle);
        tick = w.current_tick;
        case (twnp_pkg::t_op'(w.operation))
            twnp_pkg::OP_ADD: begin
                slot = -1;
                for (int i = POOL - 1; i >= 0; i--) begin
                    if (!shadow_in_use[i]) slot = i;
                end
                if (slot < 0) begin
                    owe(twnp_pkg::KIND_FULL, 0, '0, 1'b1);
                end else begin
                    b = int'(w.expiry_time % BUCKETS);
                    shadow_in_use[slot] = 1'b1;
                    shadow_armed[slot]  = 1'b1;
                    shadow_expiry[slot] = w.expiry_time;
                    shadow_word[slot]   = w.user_word;
                    shadow_next[slot]   = shadow_head[b];
                    shadow_head[b]      = 7'(slot);
                    owe(twnp_pkg::KIND_ADDED, slot, '0, 1'b1);
                end
            end
            twnp_pkg::OP_CANCEL: begin
                if (h < POOL) shadow_armed[h] = 1'b0;
                owe(twnp_pkg::KIND_DONE, 0, '0, 1'b1);
            end
            twnp_pkg::OP_RUN: begin
                b = int'(tick % BUCKETS);
                cur = int'(shadow_head[b]);
                prev = POOL;
                guard = 0;
                fired = 0;
                while (cur < POOL && guard < POOL) begin
                    nxt = int'(shadow_next[cur]);
                    if (shadow_armed[cur] && shadow_expiry[cur] <= tick) begin
                        if (prev < POOL) shadow_next[prev] = 7'(nxt);
                        else shadow_head[b] = 7'(nxt);
                        shadow_next[cur]  = NO_LINK;
                        shadow_armed[cur] = 1'b0;
                        owe(twnp_pkg::KIND_FIRED, cur, shadow_word[cur], 1'b0);
                        fired++;
                    end else begin
                        prev = cur;
                    end
                    cur = nxt;
                    guard++;
                end
                if (fired == 0) begin
                    owe(twnp_pkg::KIND_DONE, 0, '0, 1'b1);
                end else begin
                    tail = owed_results.pop_back();
                    tail.last_of_run = 1'b1;
                    owed_results.push_back(tail);
                end
            end
            default: begin
                if (h < POOL) begin
                    // A linked entry is taken out of its bucket list first.
                    if (shadow_in_use[h]) begin
                        b = int'(shadow_expiry[h] % BUCKETS);
                        cur = int'(shadow_head[b]);
                        prev = POOL;
                        guard = 0;
                        while (cur < POOL && guard < POOL) begin
                            if (cur == h) begin
                                if (prev < POOL) shadow_next[prev] = shadow_next[cur];
                                else shadow_head[b] = shadow_next[cur];
                                break;
                            end
                            prev = cur;
                            cur = int'(shadow_next[cur]);
                            guard++;
                        end
                    end
                    shadow_in_use[h] = 1'b0;
                    shadow_armed[h]  = 1'b0;
                    shadow_expiry[h] = '0;
                    shadow_word[h]   = '0;
                    shadow_next[h]   = NO_LINK;
                end
                owe(twnp_pkg::KIND_DONE, 0, '0, 1'b1);
            end
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // No idling once the queue of pending requests runs low.
    function automatic bit is_calm();
        return pending_reqs.size() < CALM_TAIL;
    endfunction

    // Build a request; fields that the operation does not use carry noise.
    function automatic twnp_pkg::t_in_word make_req(input twnp_pkg::t_op op,
                                                    input logic [63:0] exp_t,
                                                    input logic [63:0] data, input int h,
                                                    input logic [63:0] tick);
        twnp_pkg::t_in_word w;
        w.operation    = op;
        w.expiry_time  = (op == twnp_pkg::OP_ADD) ? exp_t : rand64();
        w.user_word    = (op == twnp_pkg::OP_ADD) ? data : rand64();
        w.entry_handle = (op == twnp_pkg::OP_CANCEL || op == twnp_pkg::OP_FREE)
                       ? 6'(h) : 6'($urandom);
        w.current_tick = (op == twnp_pkg::OP_RUN) ? tick : rand64();
        return w;
    endfunction

    task automatic queue_req(input twnp_pkg::t_op op, input logic [63:0] exp_t,
                             input logic [63:0] data, input int h, input logic [63:0] tick);
        pending_reqs.push_back(make_req(op, exp_t, data, h, tick));
    endtask

    // Directed opening: tick extremes, every operation and the odd cases.
    task automatic queue_directed();
        queue_req(twnp_pkg::OP_ADD, 64'd0, '1, 0, 0);
        queue_req(twnp_pkg::OP_ADD, '1, 64'h0123_4567_89ab_cdef, 0, 0);
        queue_req(twnp_pkg::OP_ADD, 64'd773, rand64(), 0, 0);
        // Empty bucket, then an entry that is not due yet, then due.
        queue_req(twnp_pkg::OP_RUN, 0, 0, 0, 64'd4);
        queue_req(twnp_pkg::OP_RUN, 0, 0, 0, 64'd517);
        queue_req(twnp_pkg::OP_RUN, 0, 0, 0, 64'd773);
        // A cancelled timer stays linked but never fires.
        queue_req(twnp_pkg::OP_CANCEL, 0, 0, 1, 0);
        queue_req(twnp_pkg::OP_RUN, 0, 0, 0, '1);
        queue_req(twnp_pkg::OP_FREE, 0, 0, 1, 0);
        queue_req(twnp_pkg::OP_FREE, 0, 0, 1, 0);
        queue_req(twnp_pkg::OP_FREE, 0, 0, 63, 0);
        queue_req(twnp_pkg::OP_CANCEL, 0, 0, 63, 0);
        // Several entries of one bucket fire in list order.
        queue_req(twnp_pkg::OP_ADD, 64'h100, rand64(), 0, 0);
        queue_req(twnp_pkg::OP_ADD, 64'h200, rand64(), 0, 0);
        queue_req(twnp_pkg::OP_ADD, 64'h300, rand64(), 0, 0);
        queue_req(twnp_pkg::OP_RUN, 0, 0, 0, 64'h200);
        queue_req(twnp_pkg::OP_RUN, 0, 0, 0, 64'h0);
        queue_req(twnp_pkg::OP_RUN, 0, 0, 0, 64'hffff_ffff_ffff_ff00);
        queue_req(twnp_pkg::OP_FREE, 0, 0, 0, 0);
    endtask

    // A short scenario on a few buckets around one upper tick value.
    task automatic queue_scenario();
        logic [55:0] hi;
        logic [7:0]  bkt [3];
        int          adds;
        int          sel;
        sel = $urandom_range(0, 3);
        hi = (sel == 0) ? '1 : (sel == 1) ? 56'd0 : 56'({$urandom(), $urandom()});
        foreach (bkt[i]) bkt[i] = 8'($urandom);
        adds = $urandom_range(1, 8);
        for (int i = 0; i < adds; i++) begin
            queue_req(twnp_pkg::OP_ADD,
                      {hi + 56'($urandom_range(0, 2)), bkt[$urandom_range(0, 2)]},
                      rand64(), 0, 0);
        end
        for (int i = 0; i < $urandom_range(1, 6); i++) begin
            case ($urandom_range(0, 3))
                0: queue_req(twnp_pkg::OP_CANCEL, 0, 0, $urandom_range(0, POOL - 1), 0);
                1: queue_req(twnp_pkg::OP_FREE, 0, 0, $urandom_range(0, POOL - 1), 0);
                default: queue_req(twnp_pkg::OP_RUN, 0, 0, 0,
                                   {hi + 56'($urandom_range(0, 2)) - 56'd1,
                                    bkt[$urandom_range(0, 2)]});
            endcase
        end
    endtask

    // Fill the pool in one bucket, overflow it, fire the lot and release it.
    task automatic queue_flood();
        for (int i = 0; i < POOL + 3; i++) begin
            queue_req(twnp_pkg::OP_ADD, {56'(rand64() >> 8), 8'hff}, rand64(), 0, 0);
        end
        queue_req(twnp_pkg::OP_RUN, 0, 0, 0, '1);
        for (int i = 0; i < POOL; i++) queue_req(twnp_pkg::OP_FREE, 0, 0, i, 0);
    endtask

    task automatic queue_noise();
        queue_req(twnp_pkg::t_op'($urandom_range(0, 3)), rand64(), rand64(),
                  $urandom_range(0, 63), rand64());
    endtask

    // Driver: offers requests with bursts of idle cycles.
    int  send_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.word  <= '0;
            send_gap = 0;
            for (int i = 0; i < POOL; i++) begin
                shadow_in_use[i] = 1'b0;
                shadow_armed[i]  = 1'b0;
                shadow_expiry[i] = '0;
                shadow_word[i]   = '0;
                shadow_next[i]   = NO_LINK;
            end
            for (int i = 0; i < BUCKETS; i++) shadow_head[i] = NO_LINK;
        end else begin
            if (req_if.valid && req_if.ready) begin
                apply_request(req_if.word);
                reqs_taken++;
                if (!is_calm() && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 14);
            end
            if (req_if.valid && !req_if.ready) begin
                req_if.valid <= 1'b1;
            end else if (send_gap > 0) begin
                req_if.valid <= 1'b0;
                send_gap--;
            end else if (pending_reqs.size() > 0) begin
                req_if.word  <= pending_reqs.pop_front();
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result word and stalls the result side at random.
    int  recv_gap;
    int  hold_left;
    bit  hold_done;
    twnp_pkg::t_out_word want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_results.size() == 0) begin
                    flag_mismatch("result word with nothing owed");
                end else begin
                    want = owed_results.pop_front();
                    if (rsp_if.word.event_kind != want.event_kind)
                        flag_mismatch($sformatf("event_kind %0d, want %0d",
                                                rsp_if.word.event_kind, want.event_kind));
                    if (rsp_if.word.result_handle != want.result_handle)
                        flag_mismatch($sformatf("result_handle %0d, want %0d",
                                                rsp_if.word.result_handle, want.result_handle));
                    if (rsp_if.word.fired_word != want.fired_word)
                        flag_mismatch($sformatf("fired_word %h, want %h",
                                                rsp_if.word.fired_word, want.fired_word));
                    if (rsp_if.word.last_of_run != want.last_of_run)
                        flag_mismatch($sformatf("last_of_run %0b, want %0b",
                                                rsp_if.word.last_of_run, want.last_of_run));
                end
                if (!is_calm() && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 14);
            end
            // One long hold-off while the sender keeps offering.
            if (!hold_done && reqs_taken >= 60) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (recv_gap > 0) begin
                rsp_if.ready <= 1'b0;
                recv_gap--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;

        queue_directed();
        queue_flood();
        while (pending_reqs.size() < 440) begin
            if ($urandom_range(0, 9) < 8) queue_scenario();
            else queue_noise();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests taken and every owed word seen.
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || owed_results.size() != 0);
        repeat (200) @(posedge i_clk);
        if (owed_results.size() != 0) flag_mismatch("result words never delivered");

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
design/twnp_pkg.sv
design/twnp_if.sv
design/twnp_ram.sv
design/twnp_ctrl.sv
design/twnp_dp.sv
design/timer_wheel_with_node_pool.sv
tb/sv/tb_timer_wheel_with_node_pool.sv
